// ===== rtl/mte_pkg.sv =====
package mte_pkg;

  // Storage and rate defaults.
  localparam int DELAY_DEPTH_DEF    = 4096;
  localparam int SAMPLE_RATE_HZ_DEF = 16000;

  // Echo taps.
  localparam int TAP_COUNT = 7;
  localparam int TAP_MS [TAP_COUNT] = '{20, 50, 80, 100, 120, 150, 200};

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // Wet gain: (28 * level + 2) / 5 is taken as ((28 * level + 2) * WET_RECIP) >> WET_SHIFT.
  localparam int WET_SHIFT = 19;
  localparam logic [16:0] WET_RECIP = 17'd104858;

  // Configuration port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int MIX_W     = 12;
  localparam logic REG_MIX_LEVEL = 1'b0;

  // Tap gains in Q1.15.
  function automatic logic [15:0] tap_gain(input logic [2:0] idx);
    logic [15:0] g;
    case (idx)
      3'd0:    g = 16'd22938;
      3'd1:    g = 16'd16384;
      3'd2:    g = 16'd9830;
      3'd3:    g = 16'd6554;
      3'd4:    g = 16'd3277;
      3'd5:    g = 16'd1638;
      3'd6:    g = 16'd655;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/multi_tap_echo_reverb.sv =====
// Multi-tap echo reverb.
// Input samples arrive on the slave stream (s_tdata holds the signed 16-bit
// sample, s_tlast marks the end of a software buffer). Each transaction gives
// exactly one transaction on the master stream: the saturated dry/wet mix in
// m_tdata, with m_tlast copied from the input.
// The wet gain is set through the APB port: register mix_level at byte 0,
// twelve bits, wet gain = mix_level * 1.4 / 4096. Write it only while idle.
// One shared 18x18 multiplier does all the work under a step sequencer:
// seven tap products, the wet-gain scaling, and the two mix products. Tap
// reads go to a single-port-read delay memory with registered data.
// The result passes the run steps and a finish state before it loads the
// output register, and s_tready is high only while the sequencer is idle,
// so each new sample waits until the last has loaded the output register.
// The output sits in a register of its own, so the next sample is accepted
// while a result still waits; if the receiver stalls longer than one item,
// the sequencer holds its last step until the output register is free.
// Reset clears the write position, the knob and the control state. The delay
// memory itself is not cleared: a fill mark tracks which entries were written,
// and entries never written read as zero, so no clearing pass is needed.
module multi_tap_echo_reverb #(
  parameter int DELAY_DEPTH    = mte_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_RATE_HZ = mte_pkg::SAMPLE_RATE_HZ_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] dry_sample
  input  logic                          s_tlast,   // block_end
  // Output stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [15:0] mixed_sample
  output logic                          m_tlast,   // block_end_out
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mte_pkg::PADDR_W-1:0]   paddr,
  input  logic [mte_pkg::PDATA_W-1:0]   pwdata,
  output logic [mte_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int MW = mte_pkg::MUL_W;
  localparam int PW = mte_pkg::PROD_W;

  // Tap delays in samples, worked out at elaboration.
  localparam int TAP_D0 = (mte_pkg::TAP_MS[0] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;
  localparam int TAP_D1 = (mte_pkg::TAP_MS[1] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;
  localparam int TAP_D2 = (mte_pkg::TAP_MS[2] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;
  localparam int TAP_D3 = (mte_pkg::TAP_MS[3] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;
  localparam int TAP_D4 = (mte_pkg::TAP_MS[4] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;
  localparam int TAP_D5 = (mte_pkg::TAP_MS[5] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;
  localparam int TAP_D6 = (mte_pkg::TAP_MS[6] * SAMPLE_RATE_HZ / 1000) % DELAY_DEPTH;

  // Sequencer steps while running.
  localparam logic [3:0] STEP_WET_MUL  = 4'd0;
  localparam logic [3:0] STEP_WET_LOAD = 4'd1;
  localparam logic [3:0] STEP_TAP_LAST = 4'd7;
  localparam logic [3:0] STEP_DRY_MUL  = 4'd8;
  localparam logic [3:0] STEP_MIX_MUL  = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  logic [3:0] step;

  // Configuration.
  logic [mte_pkg::MIX_W-1:0] mix_level;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_level <= '0;
    end else if (cfg_wr && paddr[2] == mte_pkg::REG_MIX_LEVEL) begin
      mix_level <= pwdata[mte_pkg::MIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mte_pkg::REG_MIX_LEVEL) begin
      prdata = mte_pkg::PDATA_W'(mix_level);
    end
  end

  // Item registers and per-item accumulators.
  logic signed [15:0]   x;
  logic                 last;
  logic [14:0]          wet;
  logic signed [MW-1:0] taps;
  logic signed [PW-1:0] mix_acc;

  // Delay line position and fill mark: once the position has wrapped, every
  // entry has been written at least once.
  logic [AW-1:0] pos;
  logic          wrapped;

  // Tap address for the current step.
  logic [AW-1:0] tap_d;
  logic [AW:0]   addr_sum;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          rd_valid;

  always_comb begin
    case (step[2:0])
      3'd0:    tap_d = AW'(TAP_D0);
      3'd1:    tap_d = AW'(TAP_D1);
      3'd2:    tap_d = AW'(TAP_D2);
      3'd3:    tap_d = AW'(TAP_D3);
      3'd4:    tap_d = AW'(TAP_D4);
      3'd5:    tap_d = AW'(TAP_D5);
      3'd6:    tap_d = AW'(TAP_D6);
      default: tap_d = '0;
    endcase
    addr_sum = {1'b0, pos} + (AW + 1)'(DELAY_DEPTH) - {1'b0, tap_d};
    if (addr_sum >= (AW + 1)'(DELAY_DEPTH)) begin
      addr_sum = addr_sum - (AW + 1)'(DELAY_DEPTH);
    end
    rd_addr = addr_sum[AW-1:0];
  end

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    rd_valid <= wrapped || (rd_addr < pos);
  end

  // Shared multiplier operand selection.
  logic                 mul_en;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic [16:0]          wet_num;
  logic signed [15:0]   dry;
  logic [2:0]           gain_idx;
  logic [3:0]           step_m1;

  assign wet_num  = 17'(mix_level) * 17'd28 + 17'd2;
  assign dry      = 16'sd16384 - $signed({1'b0, wet});
  assign step_m1  = step - 4'd1;
  assign gain_idx = step_m1[2:0];
  assign mul_en   = (state == ST_RUN);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (step == STEP_WET_MUL) begin
      mul_a = $signed({1'b0, wet_num});
      mul_b = $signed({1'b0, mte_pkg::WET_RECIP});
    end else if (step <= STEP_TAP_LAST) begin
      mul_a = rd_valid ? MW'($signed(rd_data)) : '0;
      mul_b = $signed({2'b00, mte_pkg::tap_gain(gain_idx)});
    end else if (step == STEP_DRY_MUL) begin
      mul_a = MW'(dry);
      mul_b = MW'(x);
    end else begin
      mul_a = $signed({3'b000, wet});
      mul_b = taps;
    end
  end

  mte_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Tap term: product / 32768 truncated toward zero.
  logic signed [PW-1:0] tap_biased;
  logic signed [MW-1:0] tap_term;

  assign tap_biased = prod + (prod[PW-1] ? PW'(32767) : PW'(0));
  assign tap_term   = tap_biased[MW+14:15];

  // Final mix: sum / 16384 truncated toward zero, then saturated.
  logic signed [PW:0]   mix_sum;
  logic signed [PW:0]   mix_biased;
  logic signed [PW-14:0] mix_q;
  logic signed [15:0]   mix_sat;

  always_comb begin
    mix_sum    = {mix_acc[PW-1], mix_acc} + {prod[PW-1], prod};
    mix_biased = mix_sum + (mix_sum[PW] ? (PW + 1)'(16383) : (PW + 1)'(0));
    mix_q      = mix_biased[PW:14];
    if (mix_q > (PW - 13)'(32767)) begin
      mix_sat = 16'sd32767;
    end else if (mix_q < -(PW - 13)'(32768)) begin
      mix_sat = -16'sd32768;
    end else begin
      mix_sat = mix_q[15:0];
    end
  end

  // Output register and delay-line write happen together when the slot frees.
  logic out_load;
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign s_tready = (state == ST_IDLE);

  mte_delay_mem #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (out_load),
    .wr_addr (pos),
    .wr_data (x),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      pos      <= '0;
      wrapped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 4'd1;
          if (step == STEP_MIX_MUL) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
            if (pos == AW'(DELAY_DEPTH - 1)) begin
              pos     <= '0;
              wrapped <= 1'b1;
            end else begin
              pos <= pos + AW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      x    <= s_tdata;
      last <= s_tlast;
      taps <= '0;
    end
    if (state == ST_RUN) begin
      if (step == STEP_WET_LOAD) begin
        wet <= prod[mte_pkg::WET_SHIFT+14:mte_pkg::WET_SHIFT];
      end
      if (step > STEP_WET_LOAD && step <= STEP_DRY_MUL) begin
        taps <= taps + tap_term;
      end
      if (step == STEP_MIX_MUL) begin
        mix_acc <= prod;
      end
    end
    if (out_load) begin
      m_tdata <= mix_sat;
      m_tlast <= last;
    end
  end

endmodule

// ===== rtl/mte_mul.sv =====
module mte_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [mte_pkg::MUL_W-1:0]      a,
  input  logic signed [mte_pkg::MUL_W-1:0]      b,
  output logic signed [mte_pkg::PROD_W-1:0]     prod
);

  // Signed multiply with the product registered; it holds while en is low.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== rtl/mte_delay_mem.sv =====
module mte_delay_mem #(
  parameter int DEPTH = mte_pkg::DELAY_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [15:0]       wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== tb/multi_tap_echo_reverb_test.sv =====
module multi_tap_echo_reverb_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map: mix_level sits at byte 0. The next word has no register
  // behind it, and a write there must leave the knob alone.
  localparam logic [mte_pkg::PADDR_W-1:0] MIX_LEVEL_ADDR =
    mte_pkg::PADDR_W'(4 * mte_pkg::REG_MIX_LEVEL);
  localparam logic [mte_pkg::PADDR_W-1:0] NEXT_REG_ADDR  =
    mte_pkg::PADDR_W'(4 * mte_pkg::REG_MIX_LEVEL + 4);

  // Echo taps in samples at 16 kHz (20 ms ... 200 ms) and their Q1.15 gains.
  localparam int ECHO_DELAY [7] = '{320, 800, 1280, 1600, 1920, 2400, 3200};
  localparam int ECHO_GAIN  [7] = '{22938, 16384, 9830, 6554, 3277, 1638, 655};

  // Once the last owed result has arrived, the bench lets the block settle
  // before the knob is touched.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 3_000_000;

  typedef struct packed {
    logic [15:0] mixed;
    logic        block_end;
  } mix_result_t;

  typedef enum int {
    BURST_NOISE,
    BURST_HOLD,
    BURST_QUIET,
    BURST_SWING
  } burst_style_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [15:0]                  s_tdata;   // [15:0] dry_sample
  logic                         s_tlast;   // block_end
  logic                         m_tvalid;
  logic                         m_tready;
  logic [15:0]                  m_tdata;   // [15:0] mixed_sample
  logic                         m_tlast;   // block_end_out
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mte_pkg::PADDR_W-1:0]  paddr;
  logic [mte_pkg::PDATA_W-1:0]  pwdata;
  logic [mte_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  multi_tap_echo_reverb DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Our own copy of the echo memory, write pointer and knob. They track the
  // block from reset on, since reset is applied only once.
  logic signed [15:0] echo_line [4096];
  logic [11:0]        write_ptr;
  logic [11:0]        mix_knob;

  // Mixed samples still owed by the block, oldest first.
  mix_result_t        expected_mix [$];

  int                 mismatch_count;
  int                 cycle_count;

  // Idling switches. When a switch is off, that side runs flat out.
  bit                 tx_gaps_on;
  bit                 rx_stalls_on;
  int                 rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap and stall lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Computes the mix for one dry sample and then advances the echo memory the
  // way the block does: taps are read first, the new sample is written last.
  function automatic logic [15:0] predict_mix(input logic [15:0] sample);
    int          x;
    int          tap_sum;
    int          wet;
    int          dry;
    int          t;
    longint      acc;
    longint      y;
    logic [11:0] idx;
    x = int'($signed(sample));
    tap_sum = 0;
    for (t = 0; t < 7; t++) begin
      // The pointer is twelve bits wide, so the subtraction wraps around the
      // line by itself. Positions never written still hold reset zeros.
      idx = write_ptr - 12'(ECHO_DELAY[t]);
      tap_sum += (int'(echo_line[idx]) * ECHO_GAIN[t]) / 32768;
    end
    // Wet gain in Q2.14 is the knob times 5.6, rounded half up. Above 16384
    // the dry gain turns negative, which is how the design is meant to work.
    wet = (int'(mix_knob) * 56 + 5) / 10;
    dry = 16384 - wet;
    acc = longint'(dry) * longint'(x) + longint'(wet) * longint'(tap_sum);
    // SystemVerilog division truncates toward zero, as the block does.
    y = acc / 16384;
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    echo_line[write_ptr] = sample;
    write_ptr = write_ptr + 12'd1;
    return y[15:0];
  endfunction

  // Sends one sample on the input stream. Inputs change on the falling edge;
  // the transaction is taken at the first rising edge with s_tready high,
  // and the expected mix is queued right then.
  task automatic send_sample(input logic [15:0] sample, input logic block_end);
    int          gap;
    mix_result_t want;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tlast  <= block_end;
    do @(posedge clk); while (!s_tready);
    want.mixed     = predict_mix(sample);
    want.block_end = block_end;
    expected_mix.push_back(want);
  endtask

  function automatic logic [15:0] burst_sample(input burst_style_t style, input int i,
                                               input logic [15:0] level);
    case (style)
      BURST_HOLD:  return level;
      BURST_QUIET: return 16'(int'($urandom_range(0, 511)) - 256);
      BURST_SWING: return i[0] ? 16'h8000 : 16'h7FFF;
      default:     return 16'($urandom);
    endcase
  endfunction

  // A burst is one software buffer: block_end is set on its last sample and
  // now and then in the middle as well. Held levels at full scale push the
  // taps hard enough to reach the saturation limits.
  task automatic send_burst(input int count);
    burst_style_t style;
    logic [15:0]  level;
    int           i;
    style = burst_style_t'($urandom_range(0, 3));
    level = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(0, 3) == 0) level = 16'($urandom);
    for (i = 0; i < count; i++) begin
      send_sample(burst_sample(style, i, level),
                  (i == count - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  // Drops tvalid, waits for every owed result, then lets the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle. The register takes the value
  // at the rising edge where psel, penable, pwrite and pready are all high.
  task automatic write_register(input logic [mte_pkg::PADDR_W-1:0] addr,
                                input logic [mte_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Only the low twelve bits of the knob are kept; addresses with bit 2 set are
    // ignored by the block.
    if (addr == MIX_LEVEL_ADDR) mix_knob = value[mte_pkg::MIX_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Output side: random stalls on m_tready, changed on the falling edge.
  initial begin
    m_tready = 1'b0;
    rx_hold  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
      end else if (!rx_stalls_on) begin
        m_tready <= 1'b1;
      end else if (m_tready) begin
        m_tready <= 1'b0;
        rx_hold  = pick_gap();
      end else begin
        m_tready <= 1'b1;
        rx_hold  = $urandom_range(0, 20);
      end
    end
  end

  // Every output transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    mix_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_mix.size() == 0) begin
        report_mismatch($sformatf("unexpected output: mixed_sample %0d block_end_out %0b",
                                  $signed(m_tdata), m_tlast));
      end else begin
        want = expected_mix.pop_front();
        if (m_tdata !== want.mixed)
          report_mismatch($sformatf("mixed_sample: expected %0d, got %0d",
                                    $signed(want.mixed), $signed(m_tdata)));
        if (m_tlast !== want.block_end)
          report_mismatch($sformatf("block_end_out: expected %0b, got %0b",
                                    want.block_end, m_tlast));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Straight after reset the knob is zero, so the output is the dry sample;
  // all taps land on entries never written, which read as zero.
  task automatic test_reset_extremes();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    drain_results();
  endtask

  // Bits above the twelve-bit knob are dropped. All ones gives the largest
  // wet gain, which makes the dry gain negative.
  task automatic test_wide_register_write();
    write_register(MIX_LEVEL_ADDR, 32'hFFFF_FFFF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    drain_results();
    write_register(MIX_LEVEL_ADDR, 32'hA5A5_1ABC);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    drain_results();
  endtask

  // A write to an address with no register must not change the knob.
  task automatic test_unmapped_register();
    write_register(NEXT_REG_ADDR, 32'h0000_0123);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b1);
    send_sample(16'h1234, 1'b0);
    drain_results();
  endtask

  // Random buffers under a series of knob settings, extremes included. One
  // phase runs with no idling on either side.
  task automatic test_random_mix_levels();
    logic [11:0] levels [10];
    int          p;
    int          sent;
    int          n;
    levels = '{12'd0, 12'd4095, 12'd2926, 12'd1, 12'd2048, 12'd3000,
               12'd0, 12'd0, 12'd0, 12'd0};
    for (p = 6; p < 10; p++) levels[p] = 12'($urandom);
    for (p = 0; p < 10; p++) begin
      write_register(MIX_LEVEL_ADDR, {20'($urandom), levels[p]});
      tx_gaps_on   = (p != 3);
      rx_stalls_on = (p != 3);
      sent = 0;
      while (sent < 36) begin
        n = $urandom_range(4, 40);
        send_burst(n);
        sent += n;
      end
      drain_results();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // The sender stops until every owed result has arrived, then resumes with
  // the knob unchanged.
  task automatic test_pause_until_drained();
    send_burst(30);
    drain_results();
    send_burst(30);
    drain_results();
  endtask

  // Longer run so the near taps see real history from earlier buffers. Long
  // held bursts with a large knob push the mix toward the saturation limits.
  task automatic test_long_history();
    logic [11:0] levels [4];
    int          p;
    int          sent;
    int          n;
    levels = '{12'd4095, 12'd2926, 12'd0, 12'd0};
    levels[2] = 12'($urandom);
    levels[3] = 12'($urandom_range(3000, 4095));
    for (p = 0; p < 4; p++) begin
      write_register(MIX_LEVEL_ADDR, {20'($urandom), levels[p]});
      tx_gaps_on   = p[0];
      rx_stalls_on = (p != 2);
      sent = 0;
      while (sent < 90) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 140) : $urandom_range(10, 50);
        send_burst(n);
        sent += n;
      end
      drain_results();
    end
  endtask

  task automatic finish_run();
    drain_results();
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tx_gaps_on     = 1'b1;
    rx_stalls_on   = 1'b1;
    mismatch_count = 0;
    cycle_count    = 0;
    write_ptr      = '0;
    mix_knob       = '0;
    foreach (echo_line[i]) echo_line[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_extremes();
    test_wide_register_write();
    test_unmapped_register();
    test_random_mix_levels();
    test_pause_until_drained();
    test_long_history();
    finish_run();
  end

endmodule
